>>> rtl/core/mrrt_pkg.sv
// Shared types and constants for the maximum-rate request table.
// Holds the command codes, status codes, the walk token and the commit word.
// No dependencies.
`default_nettype none

package mrrt_pkg;

    localparam int ID_W          = 32;
    localparam int RATE_W        = 16;
    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_ROOT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic              free_found;
        logic [RATE_W-1:0] old_rate;
        logic [RATE_W-1:0] max_rate;
    } token_t;

    // Write strobes broadcast to all cells once the walk has finished.
    typedef struct packed {
        logic add_en;
        logic upd_en;
        logic rem_en;
    } commit_t;

endpackage

`default_nettype wire

>>> rtl/core/mrrt_if.sv
// Valid/ready channel interfaces for the maximum-rate request table.
// Depends on mrrt_pkg for field widths.
`default_nettype none

interface mrrt_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         command;
    logic signed [mrrt_pkg::ID_W-1:0]   client_id;
    logic [mrrt_pkg::RATE_W-1:0]        requested_rate;

    modport source (output valid, command, client_id, requested_rate, input ready);
    modport sink   (input valid, command, client_id, requested_rate, output ready);
endinterface

interface mrrt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               flush_valid;
    logic [mrrt_pkg::RATE_W-1:0]        flush_rate;
    logic                               from_removal;
    logic [1:0]                         status;

    modport source (output valid, flush_valid, flush_rate, from_removal, status, input ready);
    modport sink   (input valid, flush_valid, flush_rate, from_removal, status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/max_rate_request_table.sv
// Maximum-rate request table: client id / rate slots kept in a row of cells.
// A token walks the row once per request to find the id, the first free slot
// and the new maximum rate; the chosen cell is then written.
// Channels: req (sink) carries command, client_id, requested_rate; rsp
// (source) carries flush_valid, flush_rate, from_removal, status. A word
// moves when valid and ready are both high. One response word per request.
// The token visits one cell per cycle, walking the whole row. One request is
// in flight at a time: req.ready is high again in the cycle the response
// word is loaded, so a new request is taken only once the last one has
// produced its response word.
// Reset (rst_n, async, active low) empties every slot and clears the root
// and expected rates; no clearing pass is needed.
// If rsp stalls, the finished request waits in front of the response
// register and req.ready stays low until the response word is taken.
// Depends on mrrt_pkg, mrrt_if and mrrt_cell.
`default_nettype none

module max_rate_request_table #(
    parameter int TABLE_DEPTH = mrrt_pkg::DEFAULT_DEPTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mrrt_req_if.sink    req,
    mrrt_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    mrrt_pkg::cmd_t              cmd_reg;
    logic [mrrt_pkg::ID_W-1:0]   id_reg;
    logic [mrrt_pkg::RATE_W-1:0] rate_reg;
    logic [mrrt_pkg::RATE_W-1:0] root_reg;
    logic [mrrt_pkg::RATE_W-1:0] expected_reg;
    mrrt_pkg::token_t            head_reg;
    mrrt_pkg::token_t            tail_reg;
    mrrt_pkg::token_t            tok [TABLE_DEPTH+1];
    mrrt_pkg::commit_t           commit;

    logic                        out_valid_reg;
    logic                        flush_valid_reg;
    logic [mrrt_pkg::RATE_W-1:0] flush_rate_reg;
    logic                        removal_reg;
    logic [1:0]                  status_reg;

    logic                        accept;
    logic                        finish;
    logic                        flush;
    logic                        removal;
    mrrt_pkg::status_t           status;
    logic [mrrt_pkg::RATE_W-1:0] expected_next;
    logic [mrrt_pkg::RATE_W-1:0] root_next;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign finish    = (state_reg == S_COMMIT) && (!out_valid_reg || rsp.ready);

    assign rsp.valid        = out_valid_reg;
    assign rsp.flush_valid  = flush_valid_reg;
    assign rsp.flush_rate   = flush_rate_reg;
    assign rsp.from_removal = removal_reg;
    assign rsp.status       = status_reg;

    assign tok[0] = head_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            mrrt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd_reg),
                .client_id (id_reg),
                .rate      (rate_reg),
                .tok_in    (tok[gi]),
                .tok_out   (tok[gi+1]),
                .commit    (commit)
            );
        end
    endgenerate

    // Decide the outcome from the finished token
    always_comb
    begin
        commit        = '0;
        flush         = 1'b0;
        removal       = 1'b0;
        status        = mrrt_pkg::ST_IGNORED;
        expected_next = expected_reg;
        root_next     = root_reg;
        case (cmd_reg)
            mrrt_pkg::CMD_ADD:
            begin
                if (!tail_reg.found)
                begin
                    if (tail_reg.free_found)
                    begin
                        commit.add_en = finish;
                        status        = mrrt_pkg::ST_APPLIED;
                    end
                    else
                    begin
                        status = mrrt_pkg::ST_FULL;
                    end
                end
            end
            mrrt_pkg::CMD_UPDATE:
            begin
                if (tail_reg.found && (tail_reg.old_rate != rate_reg))
                begin
                    commit.upd_en = finish;
                    expected_next = tail_reg.max_rate;
                    flush         = 1'b1;
                    status        = mrrt_pkg::ST_APPLIED;
                end
            end
            mrrt_pkg::CMD_REMOVE:
            begin
                if (tail_reg.found)
                begin
                    commit.rem_en = finish;
                    status        = mrrt_pkg::ST_APPLIED;
                    if (tail_reg.old_rate == expected_reg)
                    begin
                        expected_next = tail_reg.max_rate;
                        flush         = 1'b1;
                        removal       = 1'b1;
                    end
                end
            end
            default:
            begin
                if (rate_reg != root_reg)
                begin
                    root_next     = rate_reg;
                    expected_next = tail_reg.max_rate;
                    flush         = 1'b1;
                    status        = mrrt_pkg::ST_APPLIED;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (tok[TABLE_DEPTH].valid)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            root_reg      <= '0;
            expected_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg.valid <= accept;
            if (accept)
            begin
                head_reg.found      <= 1'b0;
                head_reg.free_found <= 1'b0;
                head_reg.old_rate   <= '0;
                // Seed the running maximum with the root rate after this word
                head_reg.max_rate   <= (mrrt_pkg::cmd_t'(req.command) == mrrt_pkg::CMD_ROOT)
                                       ? req.requested_rate : root_reg;
            end
            if (finish)
            begin
                root_reg      <= root_next;
                expected_reg  <= expected_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= mrrt_pkg::cmd_t'(req.command);
            id_reg   <= $unsigned(req.client_id);
            rate_reg <= req.requested_rate;
        end
        if ((state_reg == S_WALK) && tok[TABLE_DEPTH].valid)
        begin
            tail_reg <= tok[TABLE_DEPTH];
        end
        if (finish)
        begin
            flush_valid_reg <= flush;
            flush_rate_reg  <= expected_next;
            removal_reg     <= removal;
            status_reg      <= status;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mrrt_cell.sv
// One table slot of the request table: holds id, rate and valid flag.
// Processes the walk token, registers it and hands it to the next cell.
// Depends on mrrt_pkg.
`default_nettype none

module mrrt_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mrrt_pkg::cmd_t              cmd,
    input  wire logic [mrrt_pkg::ID_W-1:0]   client_id,
    input  wire logic [mrrt_pkg::RATE_W-1:0] rate,
    input  wire mrrt_pkg::token_t            tok_in,
    output mrrt_pkg::token_t                 tok_out,
    input  wire mrrt_pkg::commit_t           commit
);

    logic                        valid_reg;
    logic [mrrt_pkg::ID_W-1:0]   client_reg;
    logic [mrrt_pkg::RATE_W-1:0] rate_reg;
    logic                        hit_reg;
    logic                        pick_reg;
    mrrt_pkg::token_t            tok_reg;
    mrrt_pkg::token_t            tok_next;
    logic                        match;
    logic                        contrib_en;
    logic [mrrt_pkg::RATE_W-1:0] contrib_val;

    assign match   = valid_reg && (client_reg == client_id);
    assign tok_out = tok_reg;

    always_comb
    begin
        tok_next    = tok_in;
        contrib_en  = valid_reg;
        contrib_val = rate_reg;
        if (match)
        begin
            tok_next.found    = 1'b1;
            tok_next.old_rate = rate_reg;
            // Count the slot as it will be after the update or removal
            if (cmd == mrrt_pkg::CMD_UPDATE)
            begin
                contrib_val = rate;
            end
            else if (cmd == mrrt_pkg::CMD_REMOVE)
            begin
                contrib_en = 1'b0;
            end
        end
        if (!valid_reg)
        begin
            tok_next.free_found = 1'b1;
        end
        if (contrib_en && (contrib_val > tok_in.max_rate))
        begin
            tok_next.max_rate = contrib_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            pick_reg  <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (tok_in.valid)
            begin
                hit_reg  <= match;
                pick_reg <= !valid_reg && !tok_in.free_found;
            end
            if (commit.add_en && pick_reg)
            begin
                valid_reg <= 1'b1;
            end
            else if (commit.rem_en && hit_reg)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.add_en && pick_reg)
        begin
            client_reg <= client_id;
            rate_reg   <= rate;
        end
        else if (commit.upd_en && hit_reg)
        begin
            rate_reg <= rate;
        end
    end

endmodule

`default_nettype wire
